// ----- rtl/nap_pkg.sv -----
// Shared types and constants for the noise panic alarm controller.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package nap_pkg;

   // Widths of the item fields
   localparam int unsigned PctWidth  = 7;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned MsWidth   = 16;

   // Largest threshold that a register write may leave behind
   localparam logic [PctWidth-1:0] PctMax = 7'd100;

   // Stream payload widths, padded to whole bytes
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned ReqUserWidth = 8;
   localparam int unsigned RspDataWidth = 16;

   // Configuration port
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [1:0] {
      REG_TRIGGER_PERCENT = 2'd0,
      REG_QUALIFY_MS      = 2'd1,
      REG_RELEASE_MS      = 2'd2,
      REG_AUDIO_ENABLED   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_MANUAL  = 2'd1,
      CMD_ENABLE  = 2'd2,
      CMD_DISABLE = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_QUAL    = 5'b00010,
      ST_ACTIVE  = 5'b00100,
      ST_RELEASE = 5'b01000,
      ST_LOCK    = 5'b10000
   } fsm_state_type;

   // Codes reported in state_code
   localparam logic [2:0] CodeIdle    = 3'd0;
   localparam logic [2:0] CodeQual    = 3'd1;
   localparam logic [2:0] CodeActive  = 3'd2;
   localparam logic [2:0] CodeRelease = 3'd3;
   localparam logic [2:0] CodeLock    = 3'd4;

   typedef struct packed {
      logic [PctWidth-1:0] trigger_percent;
      logic [MsWidth-1:0]  qualify_ms;
      logic [MsWidth-1:0]  release_ms;
      logic                audio_enabled;
   } cfg_type;

   typedef struct packed {
      fsm_state_type        fsm_state;
      logic [TimeWidth-1:0] state_start_ms;
      logic                 enabled_flag;
      logic                 manual_latch;
   } ctl_state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [PctWidth-1:0]  level_percent;
      logic [TimeWidth-1:0] now_ms;
      logic                 motor_active;
      logic                 motor_lockout;
      logic                 motor_can_start;
   } req_item_type;

   typedef struct packed {
      logic [2:0] state_code;
      logic       motor_start;
      logic       motor_stop;
      logic       clear_lockout;
      logic       siren_on;
      logic       siren_unlock;
      logic       manual_ok;
   } rsp_item_type;

   // Map the one-hot state onto its reported code
   function automatic logic [2:0] state_code_of(fsm_state_type st);
      logic [2:0] code;
      unique case (st)
         ST_QUAL:    code = CodeQual;
         ST_ACTIVE:  code = CodeActive;
         ST_RELEASE: code = CodeRelease;
         ST_LOCK:    code = CodeLock;
         default:    code = CodeIdle;
      endcase
      return code;
   endfunction

endpackage

// ----- rtl/nap_csr.sv -----
// Configuration registers of the alarm controller behind an APB-style port.
// Depends on nap_pkg for register indexes, widths and the config struct.
module nap_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nap_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [nap_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [nap_pkg::CsrDataWidth-1:0]  prdata,
   output nap_pkg::cfg_type                  cfg
);

   nap_pkg::cfg_type      cfg_ff, cfg_in;
   nap_pkg::reg_index_type index;
   logic                  wr_en;
   logic [nap_pkg::PctWidth-1:0] pct_raw;

   assign index   = nap_pkg::reg_index_type'(paddr[nap_pkg::CsrAddrWidth-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pct_raw = pwdata[nap_pkg::PctWidth-1:0];

   // Decode the write, clamp the threshold to full scale
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            nap_pkg::REG_TRIGGER_PERCENT:
               cfg_in.trigger_percent = (pct_raw > nap_pkg::PctMax) ? nap_pkg::PctMax : pct_raw;
            nap_pkg::REG_QUALIFY_MS:
               cfg_in.qualify_ms = pwdata[nap_pkg::MsWidth-1:0];
            nap_pkg::REG_RELEASE_MS:
               cfg_in.release_ms = pwdata[nap_pkg::MsWidth-1:0];
            nap_pkg::REG_AUDIO_ENABLED:
               cfg_in.audio_enabled = pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_percent <= 7'd80;
         cfg_ff.qualify_ms      <= 16'd1000;
         cfg_ff.release_ms      <= 16'd3000;
         cfg_ff.audio_enabled   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      prdata = '0;
      unique case (index)
         nap_pkg::REG_TRIGGER_PERCENT: prdata[nap_pkg::PctWidth-1:0] = cfg_ff.trigger_percent;
         nap_pkg::REG_QUALIFY_MS:      prdata[nap_pkg::MsWidth-1:0]  = cfg_ff.qualify_ms;
         nap_pkg::REG_RELEASE_MS:      prdata[nap_pkg::MsWidth-1:0]  = cfg_ff.release_ms;
         nap_pkg::REG_AUDIO_ENABLED:   prdata[0]                     = cfg_ff.audio_enabled;
         default:                      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/nap_step.sv -----
// Next-state and result logic of the alarm state machine for one item.
// Depends on nap_pkg for the state, item, result and config types.
module nap_step (
   input  nap_pkg::cfg_type       cfg,
   input  nap_pkg::ctl_state_type cur,
   input  nap_pkg::req_item_type  item,
   output nap_pkg::ctl_state_type nxt,
   output nap_pkg::rsp_item_type  rsp
);

   always_comb begin
      nap_pkg::fsm_state_type        st;
      logic [nap_pkg::TimeWidth-1:0] start;
      logic [nap_pkg::TimeWidth-1:0] elapsed;
      logic                          en;
      logic                          latch;
      logic                          running;
      logic                          above;
      logic                          m_start, m_stop, clr, man_ok;

      st      = cur.fsm_state;
      start   = cur.state_start_ms;
      en      = cur.enabled_flag;
      latch   = cur.manual_latch;
      running = item.motor_active;
      m_start = 1'b0;
      m_stop  = 1'b0;
      clr     = 1'b0;
      man_ok  = 1'b0;
      above   = 1'b0;
      elapsed = '0;

      unique case (item.cmd)
         // Manual trigger: enable, latch only if the motor takes the start
         nap_pkg::CMD_MANUAL: begin
            en    = 1'b1;
            latch = item.motor_can_start;
            if (item.motor_can_start) begin
               m_start = 1'b1;
               running = 1'b1;
               man_ok  = 1'b1;
               if (st != nap_pkg::ST_ACTIVE) begin
                  st    = nap_pkg::ST_ACTIVE;
                  start = item.now_ms;
               end
            end
         end
         nap_pkg::CMD_ENABLE: begin
            en = 1'b1;
         end
         nap_pkg::CMD_DISABLE: begin
            en    = 1'b0;
            latch = 1'b0;
            if (st != nap_pkg::ST_IDLE) begin
               st    = nap_pkg::ST_IDLE;
               start = item.now_ms;
            end
         end
         default: begin
            if (!cur.enabled_flag) begin
               // Disabled tick: stop a running motor and drop to idle
               m_stop  = running;
               running = 1'b0;
               if (st != nap_pkg::ST_IDLE) begin
                  st    = nap_pkg::ST_IDLE;
                  start = item.now_ms;
               end
            end else begin
               above = latch || (item.level_percent > cfg.trigger_percent);
               // A reported lockout overrides the current state first
               if (item.motor_lockout && st != nap_pkg::ST_LOCK) begin
                  st    = nap_pkg::ST_LOCK;
                  start = item.now_ms;
               end
               elapsed = item.now_ms - start;
               unique case (st)
                  nap_pkg::ST_QUAL: begin
                     if (!above) begin
                        st    = nap_pkg::ST_IDLE;
                        start = item.now_ms;
                     end else if (elapsed >= {16'd0, cfg.qualify_ms} &&
                                  item.motor_can_start) begin
                        m_start = 1'b1;
                        running = 1'b1;
                        st      = nap_pkg::ST_ACTIVE;
                        start   = item.now_ms;
                     end
                  end
                  nap_pkg::ST_ACTIVE: begin
                     if (!running) begin
                        latch = 1'b0;
                        st    = item.motor_lockout ? nap_pkg::ST_LOCK : nap_pkg::ST_IDLE;
                        start = item.now_ms;
                     end else if (!above) begin
                        st    = nap_pkg::ST_RELEASE;
                        start = item.now_ms;
                     end
                  end
                  nap_pkg::ST_RELEASE: begin
                     if (!running) begin
                        st    = item.motor_lockout ? nap_pkg::ST_LOCK : nap_pkg::ST_IDLE;
                        start = item.now_ms;
                     end else if (above) begin
                        st    = nap_pkg::ST_ACTIVE;
                        start = item.now_ms;
                     end else if (elapsed >= {16'd0, cfg.release_ms}) begin
                        m_stop  = 1'b1;
                        running = 1'b0;
                        st      = nap_pkg::ST_IDLE;
                        start   = item.now_ms;
                     end
                  end
                  nap_pkg::ST_LOCK: begin
                     // Noise restarts the quiet window
                     if (above) begin
                        start = item.now_ms;
                     end else if (elapsed >= {16'd0, cfg.release_ms}) begin
                        clr   = 1'b1;
                        st    = nap_pkg::ST_IDLE;
                        start = item.now_ms;
                     end
                  end
                  default: begin
                     if (above) begin
                        st    = nap_pkg::ST_QUAL;
                        start = item.now_ms;
                     end
                  end
               endcase
            end
         end
      endcase

      nxt.fsm_state      = st;
      nxt.state_start_ms = start;
      nxt.enabled_flag   = en;
      nxt.manual_latch   = latch;

      rsp.state_code    = nap_pkg::state_code_of(st);
      rsp.motor_start   = m_start;
      rsp.motor_stop    = m_stop;
      rsp.clear_lockout = clr;
      rsp.siren_on      = cfg.audio_enabled & running;
      rsp.siren_unlock  = man_ok;
      rsp.manual_ok     = man_ok;
   end

endmodule

// ----- rtl/noise_panic_alarm_fsm_core.sv -----
// Top level of the noise panic alarm controller: input register, step logic,
// result register and configuration registers. Depends on nap_pkg, nap_csr, nap_step.
//
//   channel | direction | transfer when              | payload
//   req     | in        | req_tvalid & req_tready    | tdata item fields, tuser command
//   rsp     | out       | rsp_tvalid & rsp_tready    | tdata result fields
//   csr     | in/out    | psel & penable             | 32-bit write if pwrite, else read
//
// One item per cycle while the result side is not stalled; a result passes the input
// register, then the result register, before it is offered on rsp.
// Synchronous active-high reset puts the machine in idle, enabled, latch clear,
// and empties both registers; configuration returns to its defaults.
// A stalled result holds in the result register while the input register keeps
// one more item; req_tready drops only when both are full.
module noise_panic_alarm_fsm_core (
   input  logic                               clock,
   input  logic                               reset,
   // req: level_percent[6:0], now_ms[38:7], motor_active[39],
   //      motor_lockout[40], motor_can_start[41], zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nap_pkg::ReqDataWidth-1:0]   req_tdata,
   // req: cmd[1:0], zero pad
   input  logic [nap_pkg::ReqUserWidth-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp: state_code[2:0], motor_start[3], motor_stop[4], clear_lockout[5],
   //      siren_on[6], siren_unlock[7], manual_ok[8], zero pad
   output logic [nap_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nap_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [nap_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [nap_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);

   nap_pkg::cfg_type       cfg;
   nap_pkg::req_item_type  req_item;
   nap_pkg::req_item_type  item_ff, item_in;
   logic                   item_valid_ff, item_valid_in;
   nap_pkg::rsp_item_type  rsp_ff, rsp_in, step_rsp;
   logic                   rsp_valid_ff, rsp_valid_in;
   nap_pkg::ctl_state_type ctl_ff, ctl_in, step_nxt;
   logic                   out_free;
   logic                   advance;
   logic                   req_xfer;

   assign csr_pready = 1'b1;

   nap_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // Unpack the incoming transfer
   assign req_item.cmd             = nap_pkg::cmd_type'(req_tuser[1:0]);
   assign req_item.level_percent   = req_tdata[6:0];
   assign req_item.now_ms          = req_tdata[38:7];
   assign req_item.motor_active    = req_tdata[39];
   assign req_item.motor_lockout   = req_tdata[40];
   assign req_item.motor_can_start = req_tdata[41];

   // Handshake between the two register stages
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   nap_step u_step (
      .cfg  (cfg),
      .cur  (ctl_ff),
      .item (item_ff),
      .nxt  (step_nxt),
      .rsp  (step_rsp)
   );

   // Load the input register, commit state and result on advance
   always_comb begin
      item_in       = req_xfer ? req_item : item_ff;
      item_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
      ctl_in        = advance ? step_nxt : ctl_ff;
      rsp_in        = advance ? step_rsp : rsp_ff;
      rsp_valid_in  = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         item_valid_ff         <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         ctl_ff.fsm_state      <= nap_pkg::ST_IDLE;
         ctl_ff.state_start_ms <= '0;
         ctl_ff.enabled_flag   <= 1'b1;
         ctl_ff.manual_latch   <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctl_ff        <= ctl_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.manual_ok, rsp_ff.siren_unlock, rsp_ff.siren_on,
                        rsp_ff.clear_lockout, rsp_ff.motor_stop, rsp_ff.motor_start,
                        rsp_ff.state_code};

`ifndef SYNTH
   // A state change always restarts the timer at the item's time
   a_start_on_change: assert property (@(posedge clock) disable iff (reset)
      (advance && step_nxt.fsm_state != ctl_ff.fsm_state)
      |=> (ctl_ff.state_start_ms == $past(item_ff.now_ms)))
      else $error("state changed without restarting its timer");

   // Start and stop are never requested by the same item
   a_start_stop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.motor_start && rsp_ff.motor_stop))
      else $error("motor start and stop in one result");

   // A successful manual trigger leaves the machine active with a start issued
   a_manual_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.manual_ok)
      |-> (rsp_ff.motor_start && rsp_ff.state_code == nap_pkg::CodeActive))
      else $error("manual trigger result inconsistent");

   // Clearing the lockout returns to idle
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.clear_lockout) |-> (rsp_ff.state_code == nap_pkg::CodeIdle))
      else $error("lockout cleared outside idle");

   // The state only moves when an item is committed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ctl_ff))
      else $error("control state moved without an item");
`endif

endmodule
